@@ rtl/ecbr_pkg.sv @@
// Shared types, widths and codes for the expiring credit bucket ring.
package ecbr_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;
  localparam int REQ_W             = 2;
  localparam int AMOUNT_W          = 32;
  localparam int TOTAL_W           = 40;

  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONSUME = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  localparam logic [AMOUNT_W-1:0] BUCKET_MAX = {AMOUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_UPD,
    ST_TICK_UPD,
    ST_CON_WALK,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic decode;
    logic add_upd;
    logic tick_upd;
    logic con_upd;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             in_valid;
    logic [REQ_W-1:0] req_type;
    logic             con_skip;
    logic             walk_done;
    logic             out_free;
  } status_t;

endpackage

@@ rtl/ecbr_ifs.sv @@
// Request and result channel interfaces for the credit bucket ring.
interface ecbr_req_if;
  logic                             valid;
  logic                             ready;
  logic [ecbr_pkg::REQ_W-1:0]       req_type;
  logic [ecbr_pkg::AMOUNT_W-1:0]    amount;

  modport source (output valid, output req_type, output amount, input ready);
  modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface ecbr_res_if;
  logic                             valid;
  logic                             ready;
  logic [ecbr_pkg::AMOUNT_W-1:0]    unmet;
  logic [ecbr_pkg::TOTAL_W-1:0]     total_credit;

  modport source (output valid, output unmet, output total_credit, input ready);
  modport sink   (input valid, input unmet, input total_credit, output ready);
endinterface

@@ rtl/ecbr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ecbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ecbr_ctrl.sv @@
// Controller state machine for the credit bucket ring.
module ecbr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ecbr_pkg::status_t st,
  output ecbr_pkg::cmd_t    cmd
);

  ecbr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ecbr_pkg::ST_IDLE: begin
        if (st.in_valid) state_next = ecbr_pkg::ST_DECODE;
      end
      ecbr_pkg::ST_DECODE: begin
        case (st.req_type)
          ecbr_pkg::REQ_ADD:     state_next = ecbr_pkg::ST_ADD_UPD;
          ecbr_pkg::REQ_TICK:    state_next = ecbr_pkg::ST_TICK_UPD;
          ecbr_pkg::REQ_CONSUME: state_next = st.con_skip ? ecbr_pkg::ST_RESULT
                                                          : ecbr_pkg::ST_CON_WALK;
          default:               state_next = ecbr_pkg::ST_RESULT;
        endcase
      end
      ecbr_pkg::ST_ADD_UPD:  state_next = ecbr_pkg::ST_RESULT;
      ecbr_pkg::ST_TICK_UPD: state_next = ecbr_pkg::ST_RESULT;
      ecbr_pkg::ST_CON_WALK: begin
        if (st.walk_done) state_next = ecbr_pkg::ST_RESULT;
      end
      ecbr_pkg::ST_RESULT: begin
        if (st.out_free) state_next = ecbr_pkg::ST_IDLE;
      end
      default: state_next = ecbr_pkg::ST_IDLE;
    endcase
  end

  // Hold ready low while reset is asserted so no beat is taken and dropped.
  always_comb begin
    cmd          = '0;
    cmd.in_ready = (state == ecbr_pkg::ST_IDLE) && !rst;
    cmd.accept   = (state == ecbr_pkg::ST_IDLE) && !rst && st.in_valid;
    cmd.decode   = (state == ecbr_pkg::ST_DECODE);
    cmd.add_upd  = (state == ecbr_pkg::ST_ADD_UPD);
    cmd.tick_upd = (state == ecbr_pkg::ST_TICK_UPD);
    cmd.con_upd  = (state == ecbr_pkg::ST_CON_WALK);
    cmd.load_out = (state == ecbr_pkg::ST_RESULT) && st.out_free;
  end

endmodule

@@ rtl/ecbr_dp.sv @@
// Datapath for the credit bucket ring: slot pointers, totals, bucket RAM, result register.
module ecbr_dp #(
  parameter int NUM_SLOTS = ecbr_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  ecbr_req_if.sink          req,
  ecbr_res_if.source        res,
  input  ecbr_pkg::cmd_t    cmd,
  output ecbr_pkg::status_t st
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int AW     = ecbr_pkg::AMOUNT_W;
  localparam int TW     = ecbr_pkg::TOTAL_W;

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(NUM_SLOTS - 1) : s - 1'b1;
  endfunction

  logic [ecbr_pkg::REQ_W-1:0] req_type;
  logic [AW-1:0]              demand, demand_next;
  logic [TW-1:0]              total, total_next;
  logic [SLOT_W-1:0]          cur;
  logic [SLOT_W-1:0]          walk_slot;
  logic [CNT_W-1:0]           walk_cnt;
  logic [NUM_SLOTS-1:0]       written;
  logic                       rd_written;

  logic                       out_valid;
  logic [AW-1:0]              out_unmet;
  logic [TW-1:0]              out_total;

  logic                       wr_en, rd_en;
  logic [SLOT_W-1:0]          wr_addr, rd_addr;
  logic [AW-1:0]              wr_data, rd_data;
  logic [AW-1:0]              bkt, room, take;

  // A bucket never written since reset reads as empty.
  assign bkt = rd_written ? rd_data : '0;

  always_comb begin
    room        = ecbr_pkg::BUCKET_MAX - bkt;
    take        = '0;
    wr_en       = 1'b0;
    wr_addr     = walk_slot;
    wr_data     = '0;
    demand_next = demand;
    total_next  = total;
    if (cmd.add_upd) begin
      take       = (req_type == ecbr_pkg::REQ_ADD && demand < room) ? demand : room;
      wr_en      = 1'b1;
      wr_addr    = cur;
      wr_data    = bkt + take;
      total_next = total + TW'(take);
    end else if (cmd.tick_upd) begin
      wr_en      = 1'b1;
      wr_data    = '0;
      total_next = total - TW'(bkt);
    end else if (cmd.con_upd) begin
      take        = (bkt < demand) ? bkt : demand;
      wr_en       = 1'b1;
      wr_data     = bkt - take;
      demand_next = demand - take;
      total_next  = total - TW'(take);
    end
  end

  always_comb begin
    rd_en   = cmd.decode || cmd.con_upd;
    rd_addr = prev_slot(walk_slot);
    if (cmd.decode) begin
      rd_addr = (req_type == ecbr_pkg::REQ_ADD) ? cur : prev_slot(cur);
    end
  end

  ecbr_ram #(
    .WIDTH (AW),
    .DEPTH (NUM_SLOTS)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      total     <= '0;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      total <= total_next;
      if (wr_en) written[wr_addr] <= 1'b1;
      if (cmd.tick_upd) cur <= walk_slot;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type <= req.req_type;
      demand   <= req.amount;
    end else begin
      demand <= demand_next;
    end
    if (rd_en) rd_written <= written[rd_addr];
    if (cmd.decode) begin
      walk_slot <= prev_slot(cur);
      walk_cnt  <= '0;
    end else if (cmd.con_upd) begin
      walk_slot <= prev_slot(walk_slot);
      walk_cnt  <= walk_cnt + 1'b1;
    end
    if (cmd.load_out) begin
      out_unmet <= (req_type == ecbr_pkg::REQ_CONSUME) ? demand : '0;
      out_total <= total;
    end
  end

  assign req.ready        = cmd.in_ready;
  assign res.valid        = out_valid;
  assign res.unmet        = out_unmet;
  assign res.total_credit = out_total;

  assign st.in_valid  = req.valid;
  assign st.req_type  = req_type;
  assign st.con_skip  = (demand == '0) || (total == '0);
  assign st.walk_done = (demand_next == '0) || (total_next == '0) ||
                        (walk_cnt == CNT_W'(NUM_SLOTS - 1));
  assign st.out_free  = !out_valid || res.ready;

endmodule

@@ rtl/expiring_credit_bucket_ring_unit.sv @@
// Top level of the expiring credit bucket ring: controller plus datapath.
//
// Channels: req carries one request beat (req_type, amount); res returns one
// result beat (unmet, total_credit) for every request, in order. A beat moves
// on a rising clk edge where valid and ready are both high.
// Request codes: add puts amount into the current bucket (saturating); tick
// steps the current slot back one place and empties the bucket found there;
// consume drains buckets starting one slot behind the current one, moving
// further back, and reports the demand left over. Code 3 does nothing.
// Timing: req.ready is high only while the unit is idle and out of reset. Add
// and tick pass through decode and an update state before their result load;
// code 3 and a consume with zero demand or zero total go from decode straight
// to the load; any other consume walks one bucket per cycle (up to NUM_SLOTS),
// since the walk reads the next bucket while it rewrites the current one. Ready
// returns in the cycle after the load, so the unit takes no new request while
// one is in flight.
// Reset (rst, synchronous): all buckets read as empty, the current slot and
// the total return to zero; no clearing pass is needed.
// Stall: a finished result waits in the output register; the unit accepts the
// next request meanwhile, and holds its next result until res frees up.
module expiring_credit_bucket_ring_unit #(
  parameter int NUM_SLOTS = ecbr_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  ecbr_req_if.sink    req,
  ecbr_res_if.source  res
);

  ecbr_pkg::cmd_t    cmd;
  ecbr_pkg::status_t st;

  // Sequence each request through decode, update and result load.
  ecbr_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // Hold the ring, pointers, total and result register.
  ecbr_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cmd (cmd),
    .st  (st)
  );

endmodule

@@ dv/expiring_credit_bucket_ring_unit_tb.sv @@
// Self-checking testbench for the expiring credit bucket ring: directed rows, then random traffic.
module expiring_credit_bucket_ring_unit_tb;
  import ecbr_pkg::*;

  localparam int NUM_SLOTS = NUM_SLOTS_DEFAULT;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_IDLE = 19;
  // Slowest beat: sender gap, a consume walk over the whole ring and a receiver stall; take it several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [AMOUNT_W-1:0] unmet;
    logic [TOTAL_W-1:0]  total_credit;
  } ring_result_t;

  // One directed row; typed rows carry a hand-written result, others use the predictor.
  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [AMOUNT_W-1:0] amount;
    logic                typed;
    logic [AMOUNT_W-1:0] unmet;
    logic [TOTAL_W-1:0]  total_credit;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 21;

  logic clk;
  logic rst;

  ecbr_req_if req_ch ();
  ecbr_res_if res_ch ();

  expiring_credit_bucket_ring_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Shadow state of the ring.
  logic [AMOUNT_W-1:0] ring_bucket [NUM_SLOTS];
  int                  ring_slot;
  logic [TOTAL_W-1:0]  ring_total;

  ring_result_t  results_due [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  bit            failed;
  bit            send_quiet;
  bit            recv_quiet;
  int unsigned   cycle_count;

  function automatic int slot_behind(int s);
    return (s == 0) ? NUM_SLOTS - 1 : s - 1;
  endfunction

  // Apply one request to the shadow ring and return the result it must produce.
  function automatic ring_result_t apply_request(logic [REQ_W-1:0] kind,
                                                 logic [AMOUNT_W-1:0] amt);
    ring_result_t        r;
    logic [AMOUNT_W-1:0] room;
    logic [AMOUNT_W-1:0] take;
    logic [AMOUNT_W-1:0] demand;
    int                  s;
    int                  n;
    r.unmet = '0;
    case (kind)
      REQ_ADD: begin
        // Saturate the bucket; count only the accepted part in the total.
        room = BUCKET_MAX - ring_bucket[ring_slot];
        take = (amt < room) ? amt : room;
        ring_bucket[ring_slot] = ring_bucket[ring_slot] + take;
        ring_total = ring_total + {{(TOTAL_W-AMOUNT_W){1'b0}}, take};
      end
      REQ_TICK: begin
        // Step back one slot and expire the oldest bucket found there.
        ring_slot = slot_behind(ring_slot);
        ring_total = ring_total - {{(TOTAL_W-AMOUNT_W){1'b0}}, ring_bucket[ring_slot]};
        ring_bucket[ring_slot] = '0;
      end
      REQ_CONSUME: begin
        // Drain oldest first; stop on met demand, empty ring or a full lap.
        demand = amt;
        s = ring_slot;
        for (n = 0; n < NUM_SLOTS && demand != 0 && ring_total != 0; n++) begin
          s = slot_behind(s);
          if (ring_bucket[s] >= demand) begin
            ring_bucket[s] = ring_bucket[s] - demand;
            ring_total = ring_total - {{(TOTAL_W-AMOUNT_W){1'b0}}, demand};
            demand = '0;
          end else begin
            demand = demand - ring_bucket[s];
            ring_total = ring_total - {{(TOTAL_W-AMOUNT_W){1'b0}}, ring_bucket[s]};
            ring_bucket[s] = '0;
          end
        end
        r.unmet = demand;
      end
      default: ;
    endcase
    r.total_credit = ring_total;
    return r;
  endfunction

  // Spread amounts over all magnitudes, with the extremes now and then.
  function automatic logic [AMOUNT_W-1:0] draw_amount();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return BUCKET_MAX;
      2: return AMOUNT_W'($urandom_range(1, 255));
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Drive one request beat; hold valid across back-to-back beats.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [AMOUNT_W-1:0] amt,
                              bit typed, ring_result_t typed_result);
    int           gap;
    ring_result_t predicted;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.amount   <= amt;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(kind, amt);
    results_due.push_back(typed ? typed_result : predicted);
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_for_results();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung handshake.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("expiring_credit_bucket_ring_unit test failed");
        $finish;
      end
    end
  end

  // Result side: stall at random, pop the oldest expectation per beat.
  initial begin
    ring_result_t want;
    int           stall;
    int           beats;
    res_ch.ready <= 1'b0;
    beats = 0;
    recv_quiet = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (beats % 128 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      beats++;
      if (results_due.size() == 0) begin
        $error("result beat with no request owed: unmet=%h total_credit=%h",
               res_ch.unmet, res_ch.total_credit);
        failed = 1'b1;
      end else begin
        want = results_due.pop_front();
        if (res_ch.unmet !== want.unmet) begin
          $error("unmet: expected %h, got %h", want.unmet, res_ch.unmet);
          failed = 1'b1;
        end
        if (res_ch.total_credit !== want.total_credit) begin
          $error("total_credit: expected %h, got %h", want.total_credit,
                 res_ch.total_credit);
          failed = 1'b1;
        end
      end
    end
  end

  // Request side and run control.
  initial begin
    ring_result_t     typed_result;
    logic [REQ_W-1:0] kind;
    int               i;
    int               pick;

    // Directed rows, walked in order from reset.
    directed_rows = '{
      // Consume with no credit returns the whole demand.
      '{REQ_CONSUME, 32'h0000_0005, 1'b1, 32'h0000_0005, 40'h00_0000_0000},
      '{REQ_TICK,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 40'h00_0000_0000},
      // Unused code does nothing.
      '{REQ_UNUSED,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 40'h00_0000_0000},
      '{REQ_ADD,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 40'h00_FFFF_FFFF},
      // Add overflow: the bucket is full, the extra is dropped.
      '{REQ_ADD,     32'h0000_0001, 1'b1, 32'h0000_0000, 40'h00_FFFF_FFFF},
      // Consume of zero changes nothing.
      '{REQ_CONSUME, 32'h0000_0000, 1'b1, 32'h0000_0000, 40'h00_FFFF_FFFF},
      '{REQ_ADD,     32'h0000_0000, 1'b1, 32'h0000_0000, 40'h00_FFFF_FFFF},
      '{REQ_TICK,    32'h0000_0000, 1'b1, 32'h0000_0000, 40'h00_FFFF_FFFF},
      '{REQ_ADD,     32'hAAAA_AAAA, 1'b0, 32'h0, 40'h0},
      '{REQ_TICK,    32'h5555_5555, 1'b0, 32'h0, 40'h0},
      '{REQ_ADD,     32'h5555_5555, 1'b0, 32'h0, 40'h0},
      '{REQ_CONSUME, 32'h0000_0010, 1'b0, 32'h0, 40'h0},
      '{REQ_CONSUME, 32'hFFFF_FFFF, 1'b0, 32'h0, 40'h0},
      // Drains the ring, leaves demand unmet.
      '{REQ_CONSUME, 32'hFFFF_FFFF, 1'b0, 32'h0, 40'h0},
      '{REQ_TICK,    32'h0000_0000, 1'b0, 32'h0, 40'h0},
      '{REQ_ADD,     32'h0000_0001, 1'b0, 32'h0, 40'h0},
      '{REQ_TICK,    32'h0000_0000, 1'b0, 32'h0, 40'h0},
      '{REQ_ADD,     32'h8000_0000, 1'b0, 32'h0, 40'h0},
      // Walk takes exactly a full lap before the demand is met.
      '{REQ_CONSUME, 32'h7FFF_FFFF, 1'b0, 32'h0, 40'h0},
      '{REQ_UNUSED,  32'h0000_0000, 1'b0, 32'h0, 40'h0},
      '{REQ_CONSUME, 32'hFFFF_FFFF, 1'b0, 32'h0, 40'h0}
    };

    failed = 1'b0;
    send_quiet = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++) ring_bucket[i] = '0;
    ring_slot = 0;
    ring_total = '0;

    rst <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_ADD;
    req_ch.amount   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      typed_result.unmet        = directed_rows[i].unmet;
      typed_result.total_credit = directed_rows[i].total_credit;
      send_request(directed_rows[i].kind, directed_rows[i].amount,
                   directed_rows[i].typed, typed_result);
    end
    req_ch.valid <= 1'b0;
    wait_for_results();

    // Random traffic: adds and consumes, with ticks often enough to wrap the ring and the unused code now and then.
    typed_result = '0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        // Hold off once until the result side has caught up.
        req_ch.valid <= 1'b0;
        wait_for_results();
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = REQ_ADD;
      else if (pick < 70) kind = REQ_CONSUME;
      else if (pick < 95) kind = REQ_TICK;
      else                kind = REQ_UNUSED;
      send_request(kind, (kind == REQ_ADD || kind == REQ_CONSUME) ? draw_amount() : $urandom,
                   1'b0, typed_result);
    end
    req_ch.valid <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && results_due.size() == 0) begin
      $display("expiring_credit_bucket_ring_unit test passed");
    end else begin
      $display("expiring_credit_bucket_ring_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ecbr_pkg.sv
rtl/ecbr_ifs.sv
rtl/ecbr_ram.sv
rtl/ecbr_ctrl.sv
rtl/ecbr_dp.sv
rtl/expiring_credit_bucket_ring_unit.sv
dv/expiring_credit_bucket_ring_unit_tb.sv
